[sv/flmo_pkg.sv]
// Shared types and constants of the flow loss marker observer.
// No dependencies; every other file imports this package.
package flmo_pkg;

   localparam int unsigned FlowsDefault = 256;

   localparam logic [31:0] MarkerTagReset = 32'hc2115e23;
   localparam logic [31:0] ReportTagReset = 32'h2516f3b9;
   localparam logic [15:0] ShortIntervalReset = 16'd64;
   localparam logic [15:0] LongIntervalReset = 16'd128;

   localparam logic [5:0] UnsetValue = 6'd63;
   localparam logic [5:0] MaxValue = 6'd62;

   localparam logic EvMarker = 1'b0;
   localparam logic EvReport = 1'b1;

   localparam logic [1:0] RegMarkerTag = 2'd0;
   localparam logic [1:0] RegReportTag = 2'd1;
   localparam logic [1:0] RegShortInterval = 2'd2;
   localparam logic [1:0] RegLongInterval = 2'd3;

   typedef enum logic [1:0] {
      CLS_COUNT,
      CLS_MARKER,
      CLS_REPORT
   } class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_DIV,
      ST_EMIT
   } eng_state_type;

   typedef struct packed {
      logic [31:0] marker_tag;
      logic [31:0] report_tag;
      logic [15:0] short_interval;
      logic [15:0] long_interval;
   } csr_type;

   typedef struct packed {
      class_type   cls;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  first;
   } item_type;

   typedef struct packed {
      logic [63:0] addrs;
      logic [31:0] ports;
      logic        cbit;
      logic [31:0] count;
      logic [31:0] mseq;
      logic [31:0] rseq;
      logic [63:0] usum;
      logic [63:0] ssum;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] seq;
      logic [15:0] obs;
      logic [7:0]  loss;
      logic [5:0]  up;
      logic [5:0]  prev;
      logic [5:0]  upd;
      logic        rw;
      logic [7:0]  rwb;
   } event_type;

endpackage

[sv/flmo_front.sv]
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on flmo_pkg.
module flmo_front import flmo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic         req_tuser,
   input  csr_type      csr,
   input  logic         pop,
   output logic         item_vld,
   output item_type     item
);

   item_type   slot_ff [2];
   item_type   new_item;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic [31:0] tag;

   assign req_tready = (cnt_ff != 2'd2);
   assign tag = req_tdata[135:104];
   // invalid packets are taken and dropped
   assign push = req_tvalid && req_tready && req_tuser;
   assign item_vld = (cnt_ff != 2'd0);
   assign item = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.src = req_tdata[31:0];
      new_item.dst = req_tdata[63:32];
      new_item.sport = req_tdata[79:64];
      new_item.dport = req_tdata[95:80];
      new_item.first = req_tdata[103:96];
      new_item.cls = CLS_COUNT;
      if (req_tdata[103]) begin
         if (tag == csr.marker_tag) new_item.cls = CLS_MARKER;
         else if (tag == csr.report_tag) new_item.cls = CLS_REPORT;
      end
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= new_item;
   end

endmodule

[sv/flmo_div.sv]
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Depends on flmo_pkg only by house convention.
module flmo_div import flmo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quo
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;
   logic [64:0] diff;

   assign done = done_ff;
   assign quo = quo_ff;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      diff = shifted - {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = 64'd0;
         quo_in = num;
         den_in = den;
         cnt_in = 7'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[64]) begin
            rem_in = diff[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 7'd0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule

[sv/flmo_engine.sv]
// Back end: flow table search, entry update, share divide and result register.
// Depends on flmo_pkg and flmo_div.
module flmo_engine import flmo_pkg::*; #(
   parameter int unsigned FLOWS = FlowsDefault
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      item_vld,
   input  item_type  item,
   output logic      pop,
   input  csr_type   csr,
   output logic      ev_valid,
   input  logic      ev_ready,
   output event_type ev
);

   localparam int unsigned IW = $clog2(FLOWS);
   localparam int unsigned FW = IW + 1;
   localparam logic [FW-1:0] FlowsCount = FW'(FLOWS);

   entry_type mem [FLOWS];
   entry_type rdata_ff;
   logic      mem_we;
   logic [IW-1:0] waddr;
   entry_type wdata;

   eng_state_type state_ff, state_in;
   item_type  item_ff, item_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [IW-1:0] issue_idx_ff, issue_idx_in;
   logic      issue_done_ff, issue_done_in;
   logic      cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   entry_type ent_ff, ent_in;
   logic      hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic      min_vld_ff, min_vld_in;
   logic [31:0] min_stamp_ff, min_stamp_in;
   logic [IW-1:0] min_idx_ff, min_idx_in;
   logic [31:0] stamp_ff, stamp_in;
   event_type ev_ff, ev_in;
   event_type out_ff, out_in;
   logic      out_vld_ff, out_vld_in;
   logic [63:0] su_ff, su_in;
   logic [63:0] ss_ff, ss_in;
   logic      div_go_ff, div_go_in;
   logic      div_done;
   logic [63:0] div_quo;
   logic [63:0] div_num;
   logic [IW-1:0] last_idx;
   logic [63:0] key_addrs;
   logic [31:0] key_ports;

   assign ev_valid = out_vld_ff;
   assign ev = out_ff;
   assign last_idx = IW'(fill_ff - FW'(1));
   assign key_addrs = {item_ff.src, item_ff.dst};
   assign key_ports = {item_ff.sport, item_ff.dport};
   // upstream sum times 62, wrapping at 64 bits, plus half the divisor for rounding
   assign div_num = ({su_ff[57:0], 6'd0} - {su_ff[62:0], 1'b0}) + {1'b0, ss_ff[63:1]};

   flmo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (div_num),
      .den   (ss_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      logic [31:0] cnt1;
      logic [31:0] expect_cnt;
      logic [31:0] loss;
      logic [5:0]  v;
      logic        full;
      entry_type   e;

      state_in = state_ff;
      item_in = item_ff;
      fill_in = fill_ff;
      issue_idx_in = issue_idx_ff;
      issue_done_in = issue_done_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = issue_idx_ff;
      ent_in = ent_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      min_vld_in = min_vld_ff;
      min_stamp_in = min_stamp_ff;
      min_idx_in = min_idx_ff;
      stamp_in = stamp_ff;
      ev_in = ev_ff;
      su_in = su_ff;
      ss_in = ss_ff;
      div_go_in = 1'b0;
      pop = 1'b0;
      mem_we = 1'b0;
      waddr = hit_idx_ff;
      e = ent_ff;
      wdata = ent_ff;
      cnt1 = ent_ff.count + 32'd1;
      expect_cnt = 32'd0;
      loss = 32'd0;
      v = UnsetValue;
      full = (fill_ff == FlowsCount);
      out_in = out_ff;
      out_vld_in = out_vld_ff && !ev_ready;

      case (state_ff)
         ST_IDLE: begin
            if (item_vld) begin
               pop = 1'b1;
               item_in = item;
               hit_in = 1'b0;
               min_vld_in = 1'b0;
               issue_idx_in = '0;
               issue_done_in = 1'b0;
               state_in = (fill_ff == '0) ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!issue_done_ff) begin
               cmp_vld_in = 1'b1;
               if (issue_idx_ff == last_idx) issue_done_in = 1'b1;
               else issue_idx_in = issue_idx_ff + IW'(1);
            end
            if (cmp_vld_ff) begin
               if (rdata_ff.addrs == key_addrs && rdata_ff.ports == key_ports) begin
                  hit_in = 1'b1;
                  hit_idx_in = cmp_idx_ff;
                  ent_in = rdata_ff;
                  cmp_vld_in = 1'b0;
                  state_in = ST_UPDATE;
               end else begin
                  if (!min_vld_ff || rdata_ff.stamp < min_stamp_ff) begin
                     min_vld_in = 1'b1;
                     min_stamp_in = rdata_ff.stamp;
                     min_idx_in = cmp_idx_ff;
                  end
                  if (cmp_idx_ff == last_idx) begin
                     cmp_vld_in = 1'b0;
                     state_in = ST_UPDATE;
                  end
               end
            end
         end
         ST_UPDATE: begin
            ev_in = '0;
            ev_in.src = item_ff.src;
            ev_in.dst = item_ff.dst;
            ev_in.up = UnsetValue;
            state_in = ST_EMIT;
            if (hit_ff) begin
               e.count = cnt1;
               e.stamp = stamp_ff;
               stamp_in = stamp_ff + 32'd1;
               mem_we = 1'b1;
            end
            case (item_ff.cls)
               CLS_MARKER: begin
                  ev_in.kind = EvMarker;
                  if (hit_ff) begin
                     expect_cnt = {16'd0, (item_ff.first[5] == ent_ff.cbit) ?
                                  csr.long_interval : csr.short_interval};
                     if (cnt1 < expect_cnt) loss = expect_cnt - cnt1;
                     e.usum = ent_ff.usum + {32'd0, loss};
                     e.ssum = ent_ff.ssum + {59'd0, item_ff.first[4:0]};
                     e.mseq = ent_ff.mseq + 32'd1;
                     e.count = 32'd0;
                     e.cbit = item_ff.first[5];
                     ev_in.seq = e.mseq;
                     ev_in.obs = cnt1[15:0];
                     ev_in.loss = loss[7:0];
                     su_in = e.usum;
                     ss_in = e.ssum;
                     if (e.ssum != 64'd0) begin
                        div_go_in = 1'b1;
                        state_in = ST_DIV;
                     end
                  end else begin
                     // allocate: next free slot, else evict the least recent
                     waddr = full ? min_idx_ff : fill_ff[IW-1:0];
                     if (!full) fill_in = fill_ff + FW'(1);
                     e.addrs = key_addrs;
                     e.ports = key_ports;
                     e.cbit = item_ff.first[5];
                     e.count = 32'd0;
                     e.mseq = 32'd1;
                     e.rseq = 32'd0;
                     e.usum = 64'd0;
                     e.ssum = 64'd0;
                     e.stamp = stamp_ff;
                     stamp_in = stamp_ff + 32'd1;
                     mem_we = 1'b1;
                     ev_in.seq = 32'd1;
                  end
               end
               CLS_REPORT: begin
                  ev_in.kind = EvReport;
                  ev_in.prev = item_ff.first[5:0];
                  ev_in.upd = item_ff.first[5:0];
                  ev_in.rwb = item_ff.first;
                  if (hit_ff) begin
                     e.rseq = ent_ff.rseq + 32'd1;
                     ev_in.seq = e.rseq;
                     su_in = ent_ff.usum;
                     ss_in = ent_ff.ssum;
                     if (ent_ff.ssum != 64'd0) begin
                        div_go_in = 1'b1;
                        state_in = ST_DIV;
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
            wdata = e;
         end
         ST_DIV: begin
            if (div_done) begin
               v = (div_quo > {58'd0, MaxValue}) ? MaxValue : div_quo[5:0];
               ev_in.up = v;
               if (ev_ff.kind == EvReport) begin
                  ev_in.upd = v;
                  ev_in.rw = (v != ev_ff.prev);
                  ev_in.rwb = (v != ev_ff.prev) ? {item_ff.first[7:6], v} : item_ff.first;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_vld_ff || ev_ready) begin
               out_in = ev_ff;
               out_vld_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         cmp_vld_ff <= 1'b0;
         issue_done_ff <= 1'b0;
         stamp_ff <= 32'd0;
         out_vld_ff <= 1'b0;
         div_go_ff <= 1'b0;
         hit_ff <= 1'b0;
         min_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         cmp_vld_ff <= cmp_vld_in;
         issue_done_ff <= issue_done_in;
         stamp_ff <= stamp_in;
         out_vld_ff <= out_vld_in;
         div_go_ff <= div_go_in;
         hit_ff <= hit_in;
         min_vld_ff <= min_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      ent_ff <= ent_in;
      hit_idx_ff <= hit_idx_in;
      min_stamp_ff <= min_stamp_in;
      min_idx_ff <= min_idx_in;
      ev_ff <= ev_in;
      out_ff <= out_in;
      su_ff <= su_in;
      ss_ff <= ss_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= wdata;
      rdata_ff <= mem[issue_idx_ff];
   end

endmodule

[sv/flow_loss_marker_observer_core.sv]
// Per-packet loss observer over an LRU flow table, top level with register block.
// Depends on flmo_pkg, flmo_front and flmo_engine.
//
// Usage: parsed UDP packets enter on the req_ stream; each gives at most one
// event on the rsp_ stream. Packets flagged with the marker tag update the
// flow's interval and loss sums; report-tagged packets return the rounded
// upstream share and a rewrite byte. Tags and intervals sit in four 32-bit
// registers on the csr_ port at byte addresses 0, 4, 8 and 12.
// Timing: a request is held in the front queue until the back end takes it; the back end
// scans the flow table one entry per cycle from its memory port, up to fill entries,
// fill being the number of flows held, takes an update step, and when a share
// is needed runs the divide (start, 64 steps, finish), then loads the result
// register. The back end works on one packet at a time.
// Reset empties the table at once (a fill count marks live entries, so no
// clearing pass) and restores register defaults. A stalled receiver holds the
// result register; the back end then waits with its next result while the
// front queue keeps taking up to two requests.
module flow_loss_marker_observer_core import flmo_pkg::*; #(
   parameter int unsigned FLOWS = FlowsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // src_addr, dst_addr, src_port_num, dst_port_num, first_byte, tag_word
   input  logic         req_tuser,   // udp_valid
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,   // ev_src, ev_dst, sequence_res, observed_count, interval_loss,
                                     // upstream_value, previous_value, updated_value, rewrite_needed,
                                     // rewrite_byte, zero pad
   output logic         rsp_tuser,   // event_kind
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   csr_type   csr_ff, csr_in;
   logic      pop;
   logic      item_vld;
   item_type  item;
   event_type ev;

   assign csr_pready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            RegMarkerTag:     csr_in.marker_tag = csr_pwdata;
            RegReportTag:     csr_in.report_tag = csr_pwdata;
            RegShortInterval: csr_in.short_interval = csr_pwdata[15:0];
            RegLongInterval:  csr_in.long_interval = csr_pwdata[15:0];
            default: ;
         endcase
      end
      case (csr_paddr[3:2])
         RegMarkerTag:     csr_prdata = csr_ff.marker_tag;
         RegReportTag:     csr_prdata = csr_ff.report_tag;
         RegShortInterval: csr_prdata = {16'd0, csr_ff.short_interval};
         RegLongInterval:  csr_prdata = {16'd0, csr_ff.long_interval};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.marker_tag <= MarkerTagReset;
         csr_ff.report_tag <= ReportTagReset;
         csr_ff.short_interval <= ShortIntervalReset;
         csr_ff.long_interval <= LongIntervalReset;
      end else begin
         csr_ff <= csr_in;
      end
   end

   flmo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr        (csr_ff),
      .pop        (pop),
      .item_vld   (item_vld),
      .item       (item)
   );

   flmo_engine #(.FLOWS(FLOWS)) u_engine (
      .clock    (clock),
      .reset    (reset),
      .item_vld (item_vld),
      .item     (item),
      .pop      (pop),
      .csr      (csr_ff),
      .ev_valid (rsp_tvalid),
      .ev_ready (rsp_tready),
      .ev       (ev)
   );

   assign rsp_tuser = ev.kind;
   assign rsp_tdata = {5'd0, ev.rwb, ev.rw, ev.upd, ev.prev, ev.up, ev.loss, ev.obs,
                       ev.seq, ev.dst, ev.src};

endmodule

[sv/flmo_checker.sv]
// Port-level checks for the flow loss marker observer, bound to the top level.
// Depends on flmo_pkg and flow_loss_marker_observer_core.
module flmo_checker import flmo_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [151:0] rsp_tdata,
   input logic         rsp_tuser
);

   // stalled result stays up
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result shown right after reset");

   a_marker_no_rewrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EvMarker |-> rsp_tdata[146:126] == 21'd0)
      else $error("marker event carries report fields");

   a_report_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EvReport |-> rsp_tdata[119:96] == 24'd0)
      else $error("report event carries count or loss");

endmodule

bind flow_loss_marker_observer_core flmo_checker u_flmo_checker (.*);
